### design/lstk_pkg.sv
// ----------------------------------------------------------------------------
// lstk_pkg
// shared types and constants for the lifo stack with peek
// ----------------------------------------------------------------------------
package lstk_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 7;
    localparam int POS_W  = 7;

    localparam logic [CAP_W-1:0]         CAP_RESET    = 7'd64;
    localparam logic signed [WORD_W-1:0] DATA_ONE     = 32'sd1;
    localparam logic signed [WORD_W-1:0] DATA_NEG_ONE = -32'sd1;
    localparam logic signed [WORD_W-1:0] DATA_ZERO    = 32'sd0;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_TOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_BADPOS   = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [WORD_W-1:0]  push_value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        status_t                   status;
        logic [CAP_W-1:0]          count;
        logic                      full_res;
        logic                      empty_res;
    } rsp_t;

    // commands broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic scan_load;
        logic scan_shift;
    } cell_cmd_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_SCAN = 1'b1
    } ctrl_state_t;

endpackage

### design/lstk_cell.sv
// ----------------------------------------------------------------------------
// lstk_cell
// one stack slot plus one scan slot; shifts with its neighbours
// ----------------------------------------------------------------------------
module lstk_cell (
    input  logic                                  clk,
    input  lstk_pkg::cell_cmd_t                   cmd,
    input  logic signed [lstk_pkg::WORD_W-1:0]    push_in,
    input  logic signed [lstk_pkg::WORD_W-1:0]    pop_in,
    input  logic signed [lstk_pkg::WORD_W-1:0]    scan_in,
    output logic signed [lstk_pkg::WORD_W-1:0]    data,
    output logic signed [lstk_pkg::WORD_W-1:0]    scan
);
    import lstk_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic signed [WORD_W-1:0] scan_reg;
    logic signed [WORD_W-1:0] scan_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.push)
        begin
            data_next = push_in;
        end
        else if (cmd.pop)
        begin
            data_next = pop_in;
        end

        scan_next = scan_reg;
        // snapshot of the stack, then walked towards the top
        if (cmd.scan_load)
        begin
            scan_next = data_reg;
        end
        else if (cmd.scan_shift)
        begin
            scan_next = scan_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        scan_reg <= scan_next;
    end

    assign data = data_reg;
    assign scan = scan_reg;

endmodule

### design/lstk_ctrl.sv
// ----------------------------------------------------------------------------
// lstk_ctrl
// fill count, capacity register, peek sequencer and result register
// ----------------------------------------------------------------------------
module lstk_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  lstk_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output lstk_pkg::rsp_t                        rsp,
    input  logic                                  cap_we,
    input  logic [lstk_pkg::CAP_W-1:0]            cap_wdata,
    input  logic signed [lstk_pkg::WORD_W-1:0]    top_data,
    input  logic signed [lstk_pkg::WORD_W-1:0]    scan_data,
    output lstk_pkg::cell_cmd_t                   cmd
);
    import lstk_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [POS_W-1:0]  steps_reg;
    logic [POS_W-1:0]  steps_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [EW-1:0]     cap_ext;
    logic [EW-1:0]     cap_eff;
    logic [EW-1:0]     count_ext;
    logic [EW-1:0]     count_next_ext;
    logic              accept;
    logic              load_rsp;
    logic signed [WORD_W-1:0] r_data;
    status_t           r_status;

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        cap_ext = EW'(cap_reg);
        if (cap_reg == '0)
        begin
            cap_eff = EW'(1);
        end
        else if (cap_ext > EW'(DEPTH))
        begin
            cap_eff = EW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign count_ext = EW'(count_reg);
    assign req_ready = (state_reg == CS_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        load_rsp       = 1'b0;
        r_data         = DATA_ZERO;
        r_status       = STATUS_OK;

        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    load_rsp = 1'b1;
                    case (req.mode)
                        MODE_PUSH:
                        begin
                            if (count_ext >= cap_eff)
                            begin
                                r_status = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                r_data   = DATA_ONE;
                                r_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                r_data     = top_data;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_PEEK:
                        begin
                            if (req.position == '0 || EW'(req.position) > count_ext)
                            begin
                                r_data   = DATA_NEG_ONE;
                                r_status = STATUS_BADPOS;
                            end
                            else
                            begin
                                // walk the snapshot up by position - 1 slots
                                load_rsp      = 1'b0;
                                cmd.scan_load = 1'b1;
                                steps_next    = req.position - 1'b1;
                                state_next    = CS_SCAN;
                            end
                        end
                        MODE_TOP:
                        begin
                            if (count_reg == '0)
                            begin
                                r_data   = DATA_NEG_ONE;
                                r_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                r_data = top_data;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b0;
                        end
                    endcase
                end
            end
            CS_SCAN:
            begin
                if (steps_reg == '0)
                begin
                    load_rsp   = 1'b1;
                    r_data     = scan_data;
                    state_next = CS_IDLE;
                end
                else
                begin
                    cmd.scan_shift = 1'b1;
                    steps_next     = steps_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        count_next_ext = EW'(count_next);
        rsp_next       = rsp_reg;
        if (load_rsp)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.data      = r_data;
            rsp_next.status    = r_status;
            rsp_next.count     = count_next_ext[CAP_W-1:0];
            rsp_next.full_res  = (count_next_ext >= cap_eff);
            rsp_next.empty_res = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cap_we)
            begin
                cap_reg <= cap_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/lifo_stack_with_peek_top.sv
// push, pop and top read: the result is registered in the cycle after acceptance, one word per
//   cycle when the consumer keeps up
// peek at position p: the scan chain loads a snapshot and walks it p - 1 slots towards the top
//   before the result is registered; no new word is taken meanwhile
// reset: fill count cleared, capacity set to 64, stack cells keep their contents
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_top
// bounded lifo of signed words built as a shifting chain of cells, with peek
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_top #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lstk_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lstk_pkg::rsp_t                rsp,
    input  logic                          cap_we,
    input  logic [lstk_pkg::CAP_W-1:0]    cap_wdata
);
    import lstk_pkg::*;

    cell_cmd_t                cmd;
    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_scan [DEPTH];

    lstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata),
        .top_data  (cell_data[0]),
        .scan_data (cell_scan[0]),
        .cmd       (cmd)
    );

    // cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] push_in;
        logic signed [WORD_W-1:0] pop_in;
        logic signed [WORD_W-1:0] scan_in;

        if (i == 0)
        begin : g_first
            assign push_in = req.push_value;
        end
        else
        begin : g_rest
            assign push_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign pop_in  = cell_data[i];
            assign scan_in = cell_scan[i];
        end
        else
        begin : g_inner
            assign pop_in  = cell_data[i+1];
            assign scan_in = cell_scan[i+1];
        end

        lstk_cell u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .push_in (push_in),
            .pop_in  (pop_in),
            .scan_in (scan_in),
            .data    (cell_data[i]),
            .scan    (cell_scan[i])
        );
    end

endmodule
